[src/pcs_pkg.sv]
package pcs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SUM_W       = WEIGHT_BITS + IDX_W;
  localparam int PROD_W      = 32 + SUM_W;
  localparam int DIV_W       = SUM_W + 1;
  localparam int NUM_W       = DIV_W + 16;
  localparam int STEP_W      = 6;

  localparam logic [STEP_W-1:0] POS_STEPS = STEP_W'(32);
  localparam logic [STEP_W-1:0] DEN_STEPS = STEP_W'(NUM_W);
  localparam logic [31:0]       DENS_SAT  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_SAMPLE_C = 2'd1,
    CMD_SAMPLE_D = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_ZERO      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_T,
    S_SPLIT,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_FETCH,
    S_FETCH_WAIT,
    S_MUL_D,
    S_MUL_A,
    S_POS_START,
    S_POS_WAIT,
    S_DEN_START,
    S_DEN_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       addr;
    logic [WEIGHT_BITS-1:0] weight;
    logic [SUM_W-1:0]       psum;
  } tbl_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem0;
    logic [NUM_W-1:0]  num;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

endpackage

[src/pcs_mul.sv]
module pcs_mul (
  input  logic                      clk,
  input  logic [31:0]               a,
  input  logic [pcs_pkg::SUM_W-1:0] b,
  output logic [pcs_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= pcs_pkg::PROD_W'(a) * pcs_pkg::PROD_W'(b);
  end

endmodule

[src/pcs_div.sv]
module pcs_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pcs_pkg::div_req_t       req,
  output logic                    busy,
  output logic                    done,
  output logic [31:0]             quot
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [pcs_pkg::DIV_W-1:0]        rem_r, rem_nxt;
  logic [pcs_pkg::NUM_W-1:0]        num_r, num_nxt;
  logic [pcs_pkg::DIV_W-1:0]        dvs_r, dvs_nxt;
  logic [pcs_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [31:0]                      q_r, q_nxt;
  logic [pcs_pkg::DIV_W:0]          shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    shifted  = {rem_r, num_r[pcs_pkg::NUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem0;
      num_nxt  = req.num;
      dvs_nxt  = req.divisor;
      cnt_nxt  = req.steps;
      q_nxt    = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[pcs_pkg::NUM_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = pcs_pkg::DIV_W'(shifted - {1'b0, dvs_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[pcs_pkg::DIV_W-1:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pcs_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

[src/pcs_table.sv]
module pcs_table (
  input  logic                            clk,
  input  pcs_pkg::tbl_wr_t                wr,
  input  logic [pcs_pkg::IDX_W-1:0]       w_addr,
  input  logic [pcs_pkg::IDX_W-1:0]       p_addr,
  output logic [pcs_pkg::WEIGHT_BITS-1:0] w_rd_r,
  output logic [pcs_pkg::SUM_W-1:0]       p_rd_r
);

  // Entry k of the prefix memory holds the sum of weights 0..k.
  logic [pcs_pkg::WEIGHT_BITS-1:0] wmem [pcs_pkg::MAX_ENTRIES];
  logic [pcs_pkg::SUM_W-1:0]       pmem [pcs_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      wmem[wr.addr] <= wr.weight;
      pmem[wr.addr] <= wr.psum;
    end
    w_rd_r <= wmem[w_addr];
    p_rd_r <= pmem[p_addr];
  end

endmodule

[src/piecewise_constant_sampler_core.sv]
// Piecewise-constant sampler. A load appends a weight with its running sum while fewer
// than 256 entries are held; the load marked last completes the table. A sample costs
// one multiply, a binary search over the prefix memory, a weight fetch, and then the
// shared restoring divider. A query takes one 41-step division. A continuous sample
// adds the divisor and offset multiplies and a 32-step position division.
// Out-of-range queries, zero totals and early commands skip the divisions.
// The block takes no new transaction until the current one has moved into the output register.
module piecewise_constant_sampler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_weight,
  input  logic        in_load_last,
  input  logic [31:0] in_random_value,
  input  logic [7:0]  in_query_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [31:0] out_position,
  output logic [31:0] out_density,
  output logic [15:0] out_weight_out
);

  localparam int IW = pcs_pkg::IDX_W;
  localparam int CW = pcs_pkg::CNT_W;
  localparam int SW = pcs_pkg::SUM_W;
  localparam int WB = pcs_pkg::WEIGHT_BITS;
  localparam int DW = pcs_pkg::DIV_W;

  pcs_pkg::state_t  state_r, state_nxt;
  pcs_pkg::cmd_t    cmd_r, cmd_nxt;
  pcs_pkg::status_t stat_r, stat_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] run_r, run_nxt;
  logic          rdy_r, rdy_nxt;
  logic [31:0]   u_r, u_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, mid_c;
  logic [CW:0]   mid_sum;
  logic [SW-1:0] t_r, t_nxt, pi_r, pi_nxt;
  logic [31:0]   r_r, r_nxt, pos_r, pos_nxt, dens_r, dens_nxt;
  logic [WB-1:0] w_r, w_nxt;
  logic [DW-1:0] d_r, d_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [7:0]    oidx_r, oidx_nxt;
  logic [31:0]   opos_r, opos_nxt, oden_r, oden_nxt;
  logic [15:0]   ow_r, ow_nxt;

  logic          s_zero, accept, out_free;
  logic [CW-1:0] n_m1, cnt_eff, lo_cl;
  logic [SW-1:0] run_eff;
  logic [DW:0]   a_sum;
  logic [DW-1:0] a_cl;

  pcs_pkg::tbl_wr_t  wr;
  pcs_pkg::div_req_t dreq;
  logic [IW-1:0]     w_addr, p_addr;
  logic [WB-1:0]     w_rd;
  logic [SW-1:0]     p_rd;
  logic [31:0]       mul_a;
  logic [SW-1:0]     mul_b;
  logic [pcs_pkg::PROD_W-1:0] prod;
  logic              div_busy, div_done;
  logic [31:0]       quot;

  pcs_table u_table (
    .clk    (clk),
    .wr     (wr),
    .w_addr (w_addr),
    .p_addr (p_addr),
    .w_rd_r (w_rd),
    .p_rd_r (p_rd)
  );

  pcs_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  pcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  assign in_ready = (state_r == pcs_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !ov_r || out_ready;
  assign s_zero   = (run_r == '0);
  assign n_m1     = cnt_r - 1'b1;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
  assign mid_c    = mid_sum[CW:1];
  assign lo_cl    = (lo_r > n_m1) ? n_m1 : lo_r;
  assign cnt_eff  = rdy_r ? '0 : cnt_r;
  assign run_eff  = rdy_r ? '0 : run_r;
  assign a_sum    = {1'b0, prod[DW-1:0]} + (DW+1)'(t_r - pi_r);
  assign a_cl     = (a_sum >= {1'b0, d_r}) ? (d_r - 1'b1) : a_sum[DW-1:0];

  assign w_addr = i_r;
  assign p_addr = (state_r == pcs_pkg::S_SRCH_ADDR) ? IW'(mid_c - 1'b1) : (i_r - 1'b1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcs_pkg::S_IDLE: begin
        if (accept) begin
          if (pcs_pkg::cmd_t'(in_command) == pcs_pkg::CMD_LOAD) begin
            state_nxt = pcs_pkg::S_IDLE;
          end else if (!rdy_r || cnt_r == '0) begin
            state_nxt = pcs_pkg::S_DONE;
          end else if (pcs_pkg::cmd_t'(in_command) == pcs_pkg::CMD_QUERY) begin
            state_nxt = ({1'b0, in_query_index} >= cnt_r) ? pcs_pkg::S_DONE
                                                          : pcs_pkg::S_FETCH;
          end else begin
            state_nxt = pcs_pkg::S_MUL_T;
          end
        end
      end
      pcs_pkg::S_MUL_T:      state_nxt = pcs_pkg::S_SPLIT;
      pcs_pkg::S_SPLIT:      state_nxt = s_zero ? pcs_pkg::S_FETCH : pcs_pkg::S_SRCH_ADDR;
      pcs_pkg::S_SRCH_ADDR:  state_nxt = (lo_r < hi_r) ? pcs_pkg::S_SRCH_CMP
                                                        : pcs_pkg::S_FETCH;
      pcs_pkg::S_SRCH_CMP:   state_nxt = pcs_pkg::S_SRCH_ADDR;
      pcs_pkg::S_FETCH:      state_nxt = pcs_pkg::S_FETCH_WAIT;
      pcs_pkg::S_FETCH_WAIT: begin
        if (s_zero) begin
          state_nxt = pcs_pkg::S_DONE;
        end else if (cmd_r == pcs_pkg::CMD_SAMPLE_C) begin
          state_nxt = pcs_pkg::S_MUL_D;
        end else begin
          state_nxt = pcs_pkg::S_DEN_START;
        end
      end
      pcs_pkg::S_MUL_D:      state_nxt = pcs_pkg::S_MUL_A;
      pcs_pkg::S_MUL_A:      state_nxt = pcs_pkg::S_POS_START;
      pcs_pkg::S_POS_START:  state_nxt = (w_r == '0) ? pcs_pkg::S_DEN_START
                                                      : pcs_pkg::S_POS_WAIT;
      pcs_pkg::S_POS_WAIT:   state_nxt = div_done ? pcs_pkg::S_DEN_START
                                                  : pcs_pkg::S_POS_WAIT;
      pcs_pkg::S_DEN_START:  state_nxt = pcs_pkg::S_DEN_WAIT;
      pcs_pkg::S_DEN_WAIT:   state_nxt = div_done ? pcs_pkg::S_DONE : pcs_pkg::S_DEN_WAIT;
      pcs_pkg::S_DONE:       state_nxt = out_free ? pcs_pkg::S_IDLE : pcs_pkg::S_DONE;
      default:               state_nxt = pcs_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_nxt  = cmd_r;
    stat_nxt = stat_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    rdy_nxt  = rdy_r;
    u_nxt    = u_r;
    i_nxt    = i_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    t_nxt    = t_r;
    r_nxt    = r_r;
    pi_nxt   = pi_r;
    w_nxt    = w_r;
    d_nxt    = d_r;
    pos_nxt  = pos_r;
    dens_nxt = dens_r;
    ov_nxt   = ov_r && !out_ready;
    ost_nxt  = ost_r;
    oidx_nxt = oidx_r;
    opos_nxt = opos_r;
    oden_nxt = oden_r;
    ow_nxt   = ow_r;
    wr       = '0;
    dreq     = '0;
    mul_a    = u_r;
    mul_b    = run_r;

    unique case (state_r)
      pcs_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt  = pcs_pkg::cmd_t'(in_command);
          u_nxt    = in_random_value;
          pos_nxt  = '0;
          dens_nxt = '0;
          w_nxt    = '0;
          i_nxt    = '0;
          stat_nxt = s_zero ? pcs_pkg::STAT_ZERO : pcs_pkg::STAT_OK;
          if (pcs_pkg::cmd_t'(in_command) == pcs_pkg::CMD_LOAD) begin
            // A load after a completed table starts a new one.
            rdy_nxt = in_load_last;
            cnt_nxt = cnt_eff;
            run_nxt = run_eff;
            if (cnt_eff < CW'(pcs_pkg::MAX_ENTRIES)) begin
              wr.en     = 1'b1;
              wr.addr   = cnt_eff[IW-1:0];
              wr.weight = in_weight[WB-1:0];
              wr.psum   = run_eff + SW'(in_weight[WB-1:0]);
              cnt_nxt   = cnt_eff + 1'b1;
              run_nxt   = run_eff + SW'(in_weight[WB-1:0]);
            end
          end else if (!rdy_r || cnt_r == '0) begin
            stat_nxt = pcs_pkg::STAT_NOT_READY;
          end else if (pcs_pkg::cmd_t'(in_command) == pcs_pkg::CMD_QUERY) begin
            i_nxt = in_query_index;
            if ({1'b0, in_query_index} >= cnt_r) begin
              stat_nxt = pcs_pkg::STAT_RANGE;
            end
          end
        end
      end
      pcs_pkg::S_MUL_T: begin
        mul_a = u_r;
        mul_b = s_zero ? SW'(cnt_r) : run_r;
      end
      pcs_pkg::S_SPLIT: begin
        if (s_zero) begin
          // Uniform pick when every weight is zero.
          i_nxt = (CW'(prod[IW+31:32]) > n_m1) ? n_m1[IW-1:0] : prod[IW+31:32];
        end else begin
          t_nxt  = prod[SW+31:32];
          r_nxt  = prod[31:0];
          lo_nxt = '0;
          hi_nxt = cnt_r;
        end
      end
      pcs_pkg::S_SRCH_ADDR: begin
        mid_nxt = mid_c;
        if (lo_r >= hi_r) begin
          i_nxt = lo_cl[IW-1:0];
        end
      end
      pcs_pkg::S_SRCH_CMP: begin
        if (p_rd <= t_r) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r - 1'b1;
        end
      end
      pcs_pkg::S_FETCH: begin
      end
      pcs_pkg::S_FETCH_WAIT: begin
        w_nxt  = w_rd;
        pi_nxt = (i_r == '0) ? '0 : p_rd;
        if (s_zero) begin
          pos_nxt  = (cmd_r == pcs_pkg::CMD_SAMPLE_C) ? u_r : '0;
          dens_nxt = pcs_pkg::DENS_SAT;
        end
      end
      pcs_pkg::S_MUL_D: begin
        mul_a = 32'(w_r);
        mul_b = SW'(cnt_r);
      end
      pcs_pkg::S_MUL_A: begin
        mul_a = 32'(w_r);
        mul_b = SW'(i_r);
        d_nxt = prod[DW-1:0];
      end
      pcs_pkg::S_POS_START: begin
        if (w_r != '0) begin
          dreq.start   = 1'b1;
          dreq.rem0    = a_cl;
          dreq.num     = {r_r, (pcs_pkg::NUM_W-32)'(0)};
          dreq.steps   = pcs_pkg::POS_STEPS;
          dreq.divisor = d_r;
        end
      end
      pcs_pkg::S_POS_WAIT: begin
        if (div_done) begin
          pos_nxt = quot;
        end
      end
      pcs_pkg::S_DEN_START: begin
        dreq.start   = 1'b1;
        dreq.rem0    = '0;
        dreq.num     = (cmd_r == pcs_pkg::CMD_SAMPLE_C) ? {d_r, 16'h0000}
                                                        : {DW'(w_r), 16'h0000};
        dreq.steps   = pcs_pkg::DEN_STEPS;
        dreq.divisor = DW'(run_r);
      end
      pcs_pkg::S_DEN_WAIT: begin
        if (div_done) begin
          dens_nxt = quot;
        end
      end
      pcs_pkg::S_DONE: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ost_nxt  = stat_r;
          oidx_nxt = i_r;
          opos_nxt = pos_r;
          oden_nxt = dens_r;
          ow_nxt   = 16'(w_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcs_pkg::S_IDLE;
      cnt_r   <= '0;
      run_r   <= '0;
      rdy_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      run_r   <= run_nxt;
      rdy_r   <= rdy_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r  <= cmd_nxt;
    stat_r <= stat_nxt;
    u_r    <= u_nxt;
    i_r    <= i_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    t_r    <= t_nxt;
    r_r    <= r_nxt;
    pi_r   <= pi_nxt;
    w_r    <= w_nxt;
    d_r    <= d_nxt;
    pos_r  <= pos_nxt;
    dens_r <= dens_nxt;
    ost_r  <= ost_nxt;
    oidx_r <= oidx_nxt;
    opos_r <= opos_nxt;
    oden_r <= oden_nxt;
    ow_r   <= ow_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_entry_index = oidx_r;
  assign out_position    = opos_r;
  assign out_density     = oden_r;
  assign out_weight_out  = ow_r;

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcs_pkg::S_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_r |-> (cnt_r != '0))
    else $error("table complete with no entries");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r == pcs_pkg::STAT_RANGE) |-> (ow_r == '0 && oden_r == '0))
    else $error("out-of-range result carries data");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcs_pkg::S_SRCH_CMP) |-> (mid_r != '0 && mid_r <= cnt_r))
    else $error("search probe outside table");

endmodule
